/* rtl/csf_pkg.sv */
// csf_pkg: shared types, constants and the crc-16/ccitt-false byte fold
// for the sync framer; no dependencies
package csf_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // most beats that one payload byte can cause: sync, sync, len, byte, crc hi, crc lo
    localparam int MAX_BEATS = 6;

    // register indexes on the config port
    localparam logic [1:0] REG_SYNC_FIRST     = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND    = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd2;

    typedef logic [2:0] beat_cnt_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fend;
    } beat_t;

    // one byte into the crc, msb first, no reflection
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/crc16_sync_framer.sv */
// crc16_sync_framer: top level of the sync framer, frames payload bytes as
// sync1 sync2 len payload crc_hi crc_lo; depends on csf_pkg and csf_beat_queue
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata[7:0] payload_byte
//  m_        out        m_tvalid / m_tready  m_tdata[7:0] out_byte, m_tlast run_last,
//                                            m_tuser frame_end
//  cfg_      in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// one output beat per cycle while m_tready is high and bytes keep arriving; a payload byte
// causes 1 beat inside a frame, 3 when it closes the frame, 4 when it opens one and 6
// when it does both (frame length 1); the six-entry beat queue hands those beats out in order
// a new byte is taken into the input register while the queue still drains, and the
// queue reloads in the same cycle its last beat leaves, so there is no bubble
// reset (synchronous, active low) clears the count, crc, registers and both valids
// m_tready low holds the queue; once the input register is full and cannot load, s_tready drops
module crc16_sync_framer import csf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] payload_byte
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last: last beat caused by one payload byte
    output logic       m_tuser,   // [0] frame_end: low crc byte that closes a frame
    // config writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // config registers, plus the crc seed folded over the length byte
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  payload_length_reg;
    logic [15:0] crc_seed_reg;

    // framing state
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  bytes_reg;
    logic [7:0]  bytes_next;

    // input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;

    // beat queue hookup
    beat_t       beats [MAX_BEATS];
    beat_cnt_t   beats_cnt;
    beat_t       q_head;
    beat_cnt_t   q_cnt;
    logic        load;
    logic        pop;

    logic        opening;
    logic        closing;
    logic [8:0]  count;
    logic [15:0] crc_base;
    beat_cnt_t   pos;

    assign cfg_ready = 1'b1;

    // config writes; the seed is refreshed with the length so the frame start
    // only needs one crc fold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg     <= 8'h00;
            sync_second_reg    <= 8'h00;
            payload_length_reg <= 8'd1;
            crc_seed_reg       <= crc_fold(CRC_INIT, 8'd1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SYNC_FIRST: begin
                    sync_first_reg <= cfg_data;
                end
                REG_SYNC_SECOND: begin
                    sync_second_reg <= cfg_data;
                end
                REG_PAYLOAD_LENGTH: begin
                    payload_length_reg <= cfg_data;
                    crc_seed_reg       <= crc_fold(CRC_INIT, cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // queue takes a byte's beats when empty or when its last beat leaves now
    assign pop      = m_tvalid && m_tready;
    assign load     = in_valid_reg &&
                      ((q_cnt == beat_cnt_t'(0)) || ((q_cnt == beat_cnt_t'(1)) && m_tready));
    assign s_tready = !in_valid_reg || load;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // beat building for the byte in the input register
    assign opening  = (bytes_reg == 8'd0);
    assign count    = {1'b0, bytes_reg} + 9'd1;
    // a zero length closes on every byte
    assign closing  = (count >= {1'b0, payload_length_reg});
    assign crc_base = opening ? crc_seed_reg : crc_reg;
    assign crc_next = crc_fold(crc_base, in_byte_reg);
    assign pos      = opening ? beat_cnt_t'(3) : beat_cnt_t'(0);

    always_comb begin
        for (int i = 0; i < MAX_BEATS; i++) begin
            beats[i] = '0;
        end
        if (opening) begin
            beats[0].data = sync_first_reg;
            beats[1].data = sync_second_reg;
            beats[2].data = payload_length_reg;
        end
        beats[pos].data = in_byte_reg;
        if (closing) begin
            beats[pos + beat_cnt_t'(1)].data = crc_next[15:8];
            beats[pos + beat_cnt_t'(2)].data = crc_next[7:0];
            beats[pos + beat_cnt_t'(2)].fend = 1'b1;
            beats_cnt = pos + beat_cnt_t'(3);
        end else begin
            beats_cnt = pos + beat_cnt_t'(1);
        end
        beats[beats_cnt - beat_cnt_t'(1)].last = 1'b1;
    end

    assign bytes_next = closing ? 8'd0 : count[7:0];

    // state advances when the byte's beats go into the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_INIT;
            bytes_reg <= 8'd0;
        end else if (load) begin
            crc_reg   <= crc_next;
            bytes_reg <= bytes_next;
        end
    end

    csf_beat_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .load_beats (beats),
        .load_cnt   (beats_cnt),
        .pop        (pop),
        .head       (q_head),
        .cnt        (q_cnt)
    );

    assign m_tvalid = (q_cnt != beat_cnt_t'(0));
    assign m_tdata  = q_head.data;
    assign m_tlast  = q_head.last;
    assign m_tuser  = q_head.fend;

endmodule

/* rtl/csf_beat_queue.sv */
// csf_beat_queue: holds the up to six beats that one payload byte causes
// and hands them out one per cycle while pop is high; depends on csf_pkg
module csf_beat_queue import csf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  beat_t     load_beats [MAX_BEATS],
    input  beat_cnt_t load_cnt,
    input  logic      pop,
    output beat_t     head,
    output beat_cnt_t cnt
);

    beat_t     buf_reg  [MAX_BEATS];
    beat_t     buf_next [MAX_BEATS];
    beat_cnt_t cnt_reg;
    beat_cnt_t cnt_next;

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = load_beats;
            cnt_next = load_cnt;
        end else if (pop) begin
            for (int i = 0; i < MAX_BEATS - 1; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - beat_cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign head = buf_reg[0];
    assign cnt  = cnt_reg;

endmodule

/* verif/crc16_sync_framer_tb.sv */
// crc16_sync_framer_tb: self-checking testbench for the crc-16 sync framer,
// predicts every wire byte of each frame and compares beat by beat
// depends on csf_pkg and the crc16_sync_framer rtl
module crc16_sync_framer_tb;
    import csf_pkg::*;

    // no accepted beat on any channel for this many cycles ends the run
    localparam int STALL_LIMIT = 1000;
    // beats still draining after the queue empties, plus margin
    localparam int DRAIN_CYCLES = 8;
    // the fourth index on the config port maps to no register
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_e;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data  = 8'h00;

    // framer state as the testbench sees it
    logic [7:0]  sync_a       = 8'h00;
    logic [7:0]  sync_b       = 8'h00;
    logic [7:0]  pay_len      = 8'd1;
    logic [15:0] crc_run      = CRC_INIT;
    logic [7:0]  payload_seen = 8'd0;

    beat_t      frame_bytes_due[$];
    int         mismatches   = 0;
    int         quiet_cycles = 0;
    int         hold_len     = 0;
    sink_mode_e sink_mode    = SINK_RANDOM;
    logic [15:0] stall_pattern = 16'hF3B7;

    crc16_sync_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // crc-16/ccitt-false, one bit at a time, msb first
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // wire bytes caused by one payload byte, queued in order
    task automatic predict_wire_bytes(input logic [7:0] b);
        beat_t      beats[$];
        logic [8:0] count;
        if (payload_seen == 8'd0) begin
            // frame opens: header goes out, crc seeded with the length byte
            beats.push_back('{data: sync_a, last: 1'b0, fend: 1'b0});
            beats.push_back('{data: sync_b, last: 1'b0, fend: 1'b0});
            beats.push_back('{data: pay_len, last: 1'b0, fend: 1'b0});
            crc_run = crc_ccitt_byte(CRC_INIT, pay_len);
        end
        beats.push_back('{data: b, last: 1'b0, fend: 1'b0});
        crc_run = crc_ccitt_byte(crc_run, b);
        count = {1'b0, payload_seen} + 9'd1;
        // a length of zero, or one lowered mid-frame, closes on this byte
        if (count >= {1'b0, pay_len}) begin
            beats.push_back('{data: crc_run[15:8], last: 1'b0, fend: 1'b0});
            beats.push_back('{data: crc_run[7:0], last: 1'b0, fend: 1'b1});
            payload_seen = 8'd0;
        end else begin
            payload_seen = count[7:0];
        end
        beats[beats.size() - 1].last = 1'b1;
        foreach (beats[i]) begin
            frame_bytes_due.push_back(beats[i]);
        end
    endtask

    // offer one payload byte, valid stays high for a following beat
    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_wire_bytes(b);
    endtask

    task automatic stop_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drain();
        while (frame_bytes_due.size() != 0) @(posedge aclk);
    endtask

    // register writes only once every predicted beat has come out
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_SYNC_FIRST:     sync_a = val;
            REG_SYNC_SECOND:    sync_b = val;
            REG_PAYLOAD_LENGTH: pay_len = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_framing(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] len);
        write_reg(REG_SYNC_FIRST, s1);
        write_reg(REG_SYNC_SECOND, s2);
        write_reg(REG_PAYLOAD_LENGTH, len);
    endtask

    // random payload in bursts, with random idle gaps bounded by gap_max between them
    task automatic send_stream(input int n, input int gap_max);
        int left;
        int burst;
        int gap;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) send_byte(8'($urandom_range(0, 255)));
            left -= burst;
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0 && left > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        stop_input();
    endtask

    // power-on values: zero sync bytes, one-byte frames
    task automatic test_reset_values();
        send_byte(8'h00);
        send_byte(8'hFF);
        stop_input();
    endtask

    task automatic test_field_extremes();
        set_framing(8'hFF, 8'h00, 8'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        stop_input();
        set_framing(8'h00, 8'hFF, 8'd2);
        send_byte(8'h5A);
        send_byte(8'hC3);
        stop_input();
    endtask

    // length byte of zero goes out as is, every byte closes a frame
    task automatic test_zero_length();
        set_framing(8'hC3, 8'h3C, 8'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h81);
        stop_input();
    endtask

    // length lowered while a frame is open: len already sent stays
    task automatic test_length_change();
        set_framing(8'h7E, 8'h81, 8'd255);
        send_byte(8'h11);
        send_byte(8'h22);
        stop_input();
        write_reg(REG_PAYLOAD_LENGTH, 8'd3);
        send_byte(8'h33);
        stop_input();
        write_reg(REG_PAYLOAD_LENGTH, 8'd4);
        send_byte(8'h44);
        stop_input();
        // count already past the new length
        write_reg(REG_PAYLOAD_LENGTH, 8'd1);
        send_byte(8'h55);
        stop_input();
    endtask

    // a write to the spare index must leave every register alone
    task automatic test_unused_index();
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(REG_UNUSED, 8'h00);
        send_byte(8'h96);
        send_byte(8'h69);
        stop_input();
    endtask

    // sink holds off long enough for the framer to stall its input,
    // then the sender waits for the output to catch up before a second stream against a random sink
    task automatic test_backpressure();
        set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd4);
        sink_mode = SINK_OPEN;
        hold_len  = 150;
        send_stream(15, 0);
        wait_drain();
        sink_mode = SINK_RANDOM;
        send_stream(15, 2);
    endtask

    // one full frame at the largest length
    task automatic test_long_frame();
        set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255);
        sink_mode = SINK_RANDOM;
        send_stream(255, 3);
    endtask

    task automatic test_random_frames();
        int gap_max;
        for (int p = 0; p < 4; p++) begin
            sink_mode     = sink_mode_e'($urandom_range(0, 2));
            // at least one ready cycle in every pattern period
            stall_pattern = 16'($urandom) | 16'h0001;
            gap_max       = ($urandom_range(0, 1) == 0) ? 0 : 4;
            set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 9)));
            send_stream(10, gap_max);
            // sometimes move the length while a frame may be open
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_PAYLOAD_LENGTH, 8'($urandom_range(0, 6)));
            end
            send_stream(10, gap_max);
        end
    endtask

    // receiver: long hold-off on request, otherwise its own stall pattern
    initial begin : sink
        int pat_pos;
        pat_pos = 0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            case (sink_mode)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_RANDOM: m_tready <= ($urandom_range(0, 99) >= 35);
                default: begin
                    m_tready <= stall_pattern[pat_pos];
                    pat_pos = (pat_pos + 1) % 16;
                end
            endcase
        end
    end

    // every output beat against the oldest predicted wire byte
    always @(posedge aclk) begin : beat_check
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_bytes_due.size() == 0) begin
                if (mismatches < 40) begin
                    $display("%0t unexpected beat: expected none actual %02h last %b end %b",
                             $time, m_tdata, m_tlast, m_tuser);
                end
                mismatches++;
            end else begin
                want = frame_bytes_due.pop_front();
                if (want.data !== m_tdata) begin
                    if (mismatches < 40) begin
                        $display("%0t out_byte: expected %02h actual %02h",
                                 $time, want.data, m_tdata);
                    end
                    mismatches++;
                end
                if (want.last !== m_tlast) begin
                    if (mismatches < 40) begin
                        $display("%0t run_last: expected %b actual %b",
                                 $time, want.last, m_tlast);
                    end
                    mismatches++;
                end
                if (want.fend !== m_tuser) begin
                    if (mismatches < 40) begin
                        $display("%0t frame_end: expected %b actual %b",
                                 $time, want.fend, m_tuser);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long with no beat accepted anywhere
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_field_extremes();
        test_zero_length();
        test_length_change();
        test_unused_index();
        test_backpressure();
        test_long_frame();
        test_random_frames();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/csf_pkg.sv
rtl/csf_beat_queue.sv
rtl/crc16_sync_framer.sv
verif/crc16_sync_framer_tb.sv
